FILE: rtl/crle_pkg.sv
// Shared types and constants for the cursor ring list engine.
package crle_pkg;

    // Ring capacity, cursor excluded
    localparam int RING_DEPTH = 16;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = $clog2(2 * RING_DEPTH);
    localparam int TOT_W      = $clog2(RING_DEPTH + 2);

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_AFTER  = 2'd0,
        OP_INS_BEFORE = 2'd1,
        OP_DEL_AFTER  = 2'd2,
        OP_DEL_BEFORE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec_op;
        logic read_done;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_read;
    } dp_stat_t;

endpackage

FILE: rtl/cursor_ring_list_engine.sv
// Top level of the cursor ring list engine: controller plus datapath.
//
// Keeps a bounded circular list of signed 32-bit words around a cursor element:
// insert after or before the cursor, delete after or before it, one result beat
// per operation with status, removed value and element count. The block works
// on one operation at a time: no new item is accepted until the last one has
// executed, and a delete that removes a ring element also waits for that
// element to come through the ring memory's registered read port. The result
// sits in an output register, so the next item is accepted while the previous
// beat is still stalled; execution waits only if that register is still full.
// No clearing pass is needed after reset.
module cursor_ring_list_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [crle_pkg::OP_W-1:0]          opcode,
    input  logic signed [crle_pkg::DATA_W-1:0] item_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [crle_pkg::STATUS_W-1:0]      status,
    output logic signed [crle_pkg::DATA_W-1:0] removed_value,
    output logic [crle_pkg::OUT_CNT_W-1:0]     element_count
);
    import crle_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    crle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // List state and ring memory
    crle_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .item_value    (item_value),
        .status        (status),
        .removed_value (removed_value),
        .element_count (element_count)
    );

endmodule

FILE: rtl/crle_ctrl.sv
// Sequencing state machine and output valid flag for the cursor ring list engine.
module crle_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  crle_pkg::dp_stat_t stat,
    output crle_pkg::dp_cmd_t  cmd
);
    import crle_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Hold state and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign in_stall  = (state_reg != S_IDLE);

    // Advance through accept, execute and optional memory read
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec_op = 1'b1;
                    if (stat.needs_read)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_done  = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/crle_dp.sv
// Datapath of the cursor ring list engine: cursor, ring indexes, ring memory, result beat.
module crle_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  crle_pkg::dp_cmd_t                 cmd,
    output crle_pkg::dp_stat_t                stat,
    input  logic [crle_pkg::OP_W-1:0]         opcode,
    input  logic signed [crle_pkg::DATA_W-1:0] item_value,
    output logic [crle_pkg::STATUS_W-1:0]     status,
    output logic signed [crle_pkg::DATA_W-1:0] removed_value,
    output logic [crle_pkg::OUT_CNT_W-1:0]    element_count
);
    import crle_pkg::*;

    // Captured item
    op_t                op_reg;
    logic [DATA_W-1:0]  val_reg;

    // List state
    logic [IDX_W-1:0]   front_reg;
    logic [IDX_W-1:0]   front_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [DATA_W-1:0]  cur_val_reg;
    logic [DATA_W-1:0]  cur_val_next;
    logic               cur_present_reg;
    logic               cur_present_next;

    // Ring memory
    logic [DATA_W-1:0]  ring_mem [RING_DEPTH];
    logic [DATA_W-1:0]  rd_data_reg;

    // Result beat
    status_t            status_reg;
    status_t            status_next;
    logic [DATA_W-1:0]  removed_reg;
    logic [DATA_W-1:0]  removed_next;
    logic [OUT_CNT_W-1:0] count_reg;

    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   front_dec;
    logic [IDX_W-1:0]   front_inc;
    logic [SUM_W-1:0]   back_sum;
    logic [SUM_W-1:0]   last_sum;
    logic [IDX_W-1:0]   back_slot;
    logic [IDX_W-1:0]   last_slot;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic               ring_full;
    logic [TOT_W-1:0]   total_next;
    logic [TOT_W+OUT_CNT_W-1:0] total_wide;

    // Wrapped ring slots
    always_comb
    begin
        front_dec = (front_reg == '0) ? IDX_W'(RING_DEPTH - 1) : front_reg - 1'b1;
        front_inc = (front_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : front_reg + 1'b1;
        back_sum  = SUM_W'(front_reg) + SUM_W'(cnt_reg);
        last_sum  = back_sum - 1'b1;
        back_slot = (back_sum >= SUM_W'(RING_DEPTH)) ?
                    IDX_W'(back_sum - SUM_W'(RING_DEPTH)) : IDX_W'(back_sum);
        last_slot = (last_sum >= SUM_W'(RING_DEPTH)) ?
                    IDX_W'(last_sum - SUM_W'(RING_DEPTH)) : IDX_W'(last_sum);
        ring_full = (cnt_reg == CNT_W'(RING_DEPTH));
    end

    // Decide the operation's effect
    always_comb
    begin
        front_next       = front_reg;
        cnt_next         = cnt_reg;
        cur_val_next     = cur_val_reg;
        cur_present_next = cur_present_reg;
        status_next      = ST_OK;
        removed_next     = '0;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        wr_addr          = back_slot;
        rd_addr          = front_reg;
        case (op_reg)
            OP_INS_AFTER, OP_INS_BEFORE:
            begin
                if (!cur_present_reg)
                begin
                    cur_val_next     = val_reg;
                    cur_present_next = 1'b1;
                end
                else if (ring_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (op_reg == OP_INS_AFTER)
                    begin
                        front_next = front_dec;
                        wr_addr    = front_dec;
                    end
                end
            end
            OP_DEL_AFTER, OP_DEL_BEFORE:
            begin
                if (!cur_present_reg)
                begin
                    status_next = ST_EMPTY;
                end
                else if (cnt_reg == '0)
                begin
                    removed_next     = cur_val_reg;
                    cur_val_next     = '0;
                    cur_present_next = 1'b0;
                end
                else
                begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    if (op_reg == OP_DEL_AFTER)
                    begin
                        front_next = front_inc;
                    end
                    else
                    begin
                        rd_addr = last_slot;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        total_next = TOT_W'(cnt_next) + TOT_W'(cur_present_next);
        total_wide = {{OUT_CNT_W{1'b0}}, total_next};
    end

    assign stat.needs_read = rd_en;

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= op_t'(opcode);
            val_reg <= item_value;
        end
    end

    // Update list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg       <= '0;
            cnt_reg         <= '0;
            cur_val_reg     <= '0;
            cur_present_reg <= 1'b0;
        end
        else if (cmd.exec_op)
        begin
            front_reg       <= front_next;
            cnt_reg         <= cnt_next;
            cur_val_reg     <= cur_val_next;
            cur_present_reg <= cur_present_next;
        end
    end

    // Ring memory: one write or one registered read per operation
    always_ff @(posedge clk)
    begin
        if (cmd.exec_op && wr_en)
        begin
            ring_mem[wr_addr] <= val_reg;
        end
        if (cmd.exec_op && rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.exec_op)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            count_reg   <= total_wide[OUT_CNT_W-1:0];
        end
        if (cmd.read_done)
        begin
            removed_reg <= rd_data_reg;
        end
    end

    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign element_count = count_reg;

endmodule

FILE: tb/tb_cursor_ring_list_engine.sv
// Self-checking testbench for the cursor ring list engine.
`timescale 1ns / 1ps

module tb_cursor_ring_list_engine;

    import crle_pkg::*;

    typedef struct {
        status_t                    st;
        logic signed [DATA_W-1:0]   removed;
        logic [OUT_CNT_W-1:0]       count;
    } list_result_t;

    // Track the list contents and check each result beat against them
    class list_scoreboard;
        logic signed [DATA_W-1:0] slots [RING_DEPTH];
        logic [IDX_W-1:0]         head;
        logic [CNT_W-1:0]         fill;
        logic signed [DATA_W-1:0] cursor_word;
        bit                       has_cursor;
        list_result_t             expected_q [$];
        int                       err_count;

        function new();
            head        = '0;
            fill        = '0;
            cursor_word = '0;
            has_cursor  = 1'b0;
            err_count   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what);
            err_count++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        // Apply one accepted operation and queue the result it must produce
        function void note_op(op_t op, logic signed [DATA_W-1:0] val);
            list_result_t r;
            r.st      = ST_OK;
            r.removed = '0;
            if (op == OP_INS_AFTER || op == OP_INS_BEFORE) begin
                if (!has_cursor) begin
                    cursor_word = val;
                    has_cursor  = 1'b1;
                end
                else if (fill >= RING_DEPTH) begin
                    r.st = ST_FULL;
                end
                else if (op == OP_INS_AFTER) begin
                    head        = IDX_W'((head + RING_DEPTH - 1) % RING_DEPTH);
                    slots[head] = val;
                    fill++;
                end
                else begin
                    slots[IDX_W'((head + fill) % RING_DEPTH)] = val;
                    fill++;
                end
            end
            else begin
                if (!has_cursor) begin
                    r.st = ST_EMPTY;
                end
                else if (fill == 0) begin
                    // Only the cursor is left: drop it and empty the list
                    r.removed   = cursor_word;
                    cursor_word = '0;
                    has_cursor  = 1'b0;
                end
                else if (op == OP_DEL_AFTER) begin
                    r.removed = slots[head];
                    head      = IDX_W'((head + 1) % RING_DEPTH);
                    fill--;
                end
                else begin
                    r.removed = slots[IDX_W'((head + fill - 1) % RING_DEPTH)];
                    fill--;
                end
            end
            r.count = OUT_CNT_W'(fill + (has_cursor ? 1 : 0));
            expected_q.push_back(r);
        endfunction

        // Compare one result beat with the oldest expectation
        task check_result(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] removed,
                          logic [OUT_CNT_W-1:0] count);
            list_result_t r;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat st=%0d rm=%0d cnt=%0d",
                                          st, removed, count));
            end
            else begin
                r = expected_q.pop_front();
                if (st !== r.st)
                    report_mismatch($sformatf("status got %0d want %0d", st, r.st));
                if (removed !== r.removed)
                    report_mismatch($sformatf("removed_value got %0d want %0d",
                                              removed, r.removed));
                if (count !== r.count)
                    report_mismatch($sformatf("element_count got %0d want %0d",
                                              count, r.count));
            end
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [OP_W-1:0]            opcode;
    logic signed [DATA_W-1:0]   item_value;
    logic                       out_valid;
    logic                       out_stall;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   removed_value;
    logic [OUT_CNT_W-1:0]       element_count;

    list_scoreboard sb;
    bit             quiet;
    int             ins_pct;

    cursor_ring_list_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .item_value    (item_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .element_count (element_count)
    );

    // Generate a 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Raise the output stall at random, except in the quiet stretch
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !quiet && ($urandom_range(0, 99) < 7);
        end
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, removed_value, element_count);
    end

    // Favor the extremes of the value range
    function logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Present one input beat and hold it until accepted
    task send_item(op_t op, logic signed [DATA_W-1:0] val);
        @(negedge clk);
        while (!quiet && ($urandom_range(0, 99) < 7))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        item_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_op(op, val);
    endtask

    // Hold off the sender until every expected result has arrived
    task wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        op_t op;
        sb         = new();
        quiet      = 1'b0;
        ins_pct    = 75;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_INS_AFTER;
        item_value = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Delete from an empty list in both directions
        send_item(OP_DEL_AFTER, 32'sd5);
        send_item(OP_DEL_BEFORE, -32'sd5);
        // Create the cursor, then remove it as the last element
        send_item(OP_INS_AFTER, 32'sh8000_0000);
        send_item(OP_DEL_BEFORE, 32'sd0);
        // Build a short list, pop both ends, then drop the cursor
        send_item(OP_INS_BEFORE, 32'sh7fff_ffff);
        send_item(OP_INS_AFTER, -32'sd1);
        send_item(OP_INS_BEFORE, 32'sd0);
        send_item(OP_DEL_AFTER, 32'sh1234_5678);
        send_item(OP_DEL_BEFORE, 32'sd0);
        send_item(OP_DEL_AFTER, 32'sd0);
        // Fill to capacity, then insert into the full list from both sides
        for (int i = 0; i < RING_DEPTH + 1; i++)
            send_item((i % 2) ? OP_INS_BEFORE : OP_INS_AFTER, pick_value());
        send_item(OP_INS_AFTER, 32'sd1);
        send_item(OP_INS_BEFORE, 32'sd2);
        wait_drain();

        // Random walk: swing between insert-heavy and delete-heavy phases
        for (int n = 0; n < 1800; n++)
        begin
            if (n % 40 == 0)
                ins_pct = (ins_pct > 50) ? 25 : 75;
            if (n % 160 == 80)
                ins_pct = 50;
            quiet = (n >= 700 && n < 1000);
            if (n % 350 == 349)
                wait_drain();
            if ($urandom_range(0, 99) < ins_pct)
                op = $urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE;
            else
                op = $urandom_range(0, 1) ? OP_DEL_AFTER : OP_DEL_BEFORE;
            send_item(op, pick_value());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain and let any stray beat show up
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("[%0t] timeout", $realtime);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
rtl/crle_pkg.sv
rtl/crle_ctrl.sv
rtl/crle_dp.sv
rtl/cursor_ring_list_engine.sv
tb/tb_cursor_ring_list_engine.sv
